// ===== hw/rtl/hcbp_pkg.sv =====
package hcbp_pkg;

    localparam int WORD_W = 32;
    localparam int LEN_W  = 6;
    localparam int SYM_W  = 8;
    localparam int CMD_W  = 2;
    localparam int PAD_W  = 5;
    localparam int TOTAL_W = LEN_W + 1;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_START  = 2'd2
    } cmd_t;

    // Control handed from the lookup stage to the packer stage
    typedef struct packed {
        logic valid;
        logic encode;
        logic start;
        logic hit;
    } lookup_t;

endpackage

// ===== hw/rtl/hcbp_if.sv =====
interface hcbp_in_if
    import hcbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SYM_W-1:0]  symbol;
    logic [WORD_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, output command, output symbol, output code_bits,
                    output code_length, input ready);
    modport sink   (input valid, input command, input symbol, input code_bits,
                    input code_length, output ready);
endinterface

interface hcbp_out_if
    import hcbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] packed_word;

    modport source (output valid, output packed_word, input ready);
    modport sink   (input valid, input packed_word, output ready);
endinterface

// ===== hw/rtl/hcbp_ram.sv =====
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hcbp_table.sv =====
module hcbp_table
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              advance,
    input  logic [CMD_W-1:0]  command,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [WORD_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_length,
    output lookup_t           lookup,
    output logic [WORD_W-1:0] code,
    output logic [LEN_W-1:0]  length
);

    localparam int AW = $clog2(SYMBOL_COUNT);

    logic                      in_range;
    logic [AW-1:0]             addr;
    logic                      is_load;
    logic                      is_encode;
    logic                      is_start;
    logic [LEN_W-1:0]          len_sat;
    logic [SYMBOL_COUNT-1:0]   written_reg;
    lookup_t                   lookup_reg;
    lookup_t                   lookup_next;
    logic [LEN_W+WORD_W-1:0]   rd_data;

    assign in_range  = {1'b0, symbol} < (SYM_W+1)'(SYMBOL_COUNT);
    assign addr      = symbol[AW-1:0];
    assign is_load   = cmd_t'(command) == CMD_LOAD;
    assign is_encode = cmd_t'(command) == CMD_ENCODE;
    assign is_start  = cmd_t'(command) == CMD_START;
    assign len_sat   = (code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                            : code_length;

    hcbp_ram #(
        .WIDTH (LEN_W + WORD_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (fire && is_load && in_range),
        .waddr (addr),
        .wdata ({len_sat, code_bits}),
        .re    (fire && is_encode && in_range),
        .raddr (addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        lookup_next        = lookup_reg;
        lookup_next.valid  = fire;
        lookup_next.encode = is_encode;
        lookup_next.start  = is_start;
        lookup_next.hit    = in_range && written_reg[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            lookup_reg  <= '0;
        end
        else
        begin
            if (fire && is_load && in_range)
            begin
                written_reg[addr] <= 1'b1;
            end
            // hold while the packer is stalled; RAM read data holds with it
            if (advance)
            begin
                lookup_reg <= lookup_next;
            end
        end
    end

    assign lookup = lookup_reg;
    assign code   = rd_data[WORD_W-1:0];
    assign length = rd_data[LEN_W+WORD_W-1:WORD_W];

endmodule

// ===== hw/rtl/hcbp_packer.sv =====
module hcbp_packer
    import hcbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [PAD_W-1:0]  cfg_wdata,
    input  lookup_t           lookup,
    input  logic [WORD_W-1:0] code,
    input  logic [LEN_W-1:0]  length,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_word
);

    logic [PAD_W-1:0]    pad_reg;
    logic [WORD_W-1:0]   buf_reg;
    logic [WORD_W-1:0]   buf_next;
    logic [PAD_W-1:0]    fill_reg;
    logic [PAD_W-1:0]    fill_next;
    logic [WORD_W-1:0]   word_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [LEN_W-1:0]    eff_len;
    logic                active;
    logic [TOTAL_W-1:0]  total;
    logic                emit;
    logic [WORD_W-1:0]   mask;
    logic [2*WORD_W-1:0] shifted;
    logic [2*WORD_W-1:0] acc;

    assign eff_len = lookup.hit ? length : '0;
    assign active  = lookup.valid && lookup.encode && (eff_len != '0);
    assign total   = TOTAL_W'(fill_reg) + TOTAL_W'(eff_len);
    assign emit    = active && (total >= TOTAL_W'(WORD_W));
    // stall only when a full word meets an occupied output register
    assign advance = !(emit && out_valid_reg && !out_ready);

    assign mask    = {WORD_W{1'b1}} >> (LEN_W'(WORD_W) - eff_len);
    assign shifted = {{WORD_W{1'b0}}, code & mask} << (TOTAL_W'(2*WORD_W) - total);
    assign acc     = {buf_reg, {WORD_W{1'b0}}} | shifted;

    always_comb
    begin
        buf_next  = buf_reg;
        fill_next = fill_reg;
        if (lookup.valid && advance)
        begin
            if (lookup.start)
            begin
                buf_next  = '0;
                fill_next = pad_reg;
            end
            else if (active && emit)
            begin
                buf_next  = acc[WORD_W-1:0];
                fill_next = PAD_W'(total - TOTAL_W'(WORD_W));
            end
            else if (active)
            begin
                buf_next  = acc[2*WORD_W-1:WORD_W];
                fill_next = total[PAD_W-1:0];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit && advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg       <= '0;
            buf_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pad_reg <= cfg_wdata;
            end
            buf_reg       <= buf_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && advance)
        begin
            word_reg <= acc[2*WORD_W-1:WORD_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hw/rtl/huffman_code_bit_packer_core.sv =====
// Channel   Modport  Payload                                     Moves
// request   sink     command, symbol, code_bits, code_length     one command
// result    source   packed_word                                 one full 32-bit word
// cfg       write    cfg_wdata (pad_bits)                        on cfg_we
//
// One request per cycle while request ready is high; an encode request that
// fills the word passes the RAM read register, then the merge output register.
// Reset clears the written flags (all lengths read as zero), the buffer, fill
// count and pad; code RAM contents stay undefined until loaded.
// A stall on result holds the merge stage and drops request ready only when a
// new full word meets an occupied output register.
module huffman_code_bit_packer_core
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [PAD_W-1:0] cfg_wdata,
    hcbp_in_if.sink          request,
    hcbp_out_if.source       result
);

    lookup_t           lookup;
    logic [WORD_W-1:0] code;
    logic [LEN_W-1:0]  length;
    logic              advance;
    logic              fire;

    assign request.ready = advance;
    assign fire          = request.valid && advance;

    hcbp_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .advance     (advance),
        .command     (request.command),
        .symbol      (request.symbol),
        .code_bits   (request.code_bits),
        .code_length (request.code_length),
        .lookup      (lookup),
        .code        (code),
        .length      (length)
    );

    hcbp_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .lookup    (lookup),
        .code      (code),
        .length    (length),
        .advance   (advance),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_word  (result.packed_word)
    );

endmodule
